// File: src/gpf_pkg.sv
// Shared types and constants of the gram presence filter.
// Used by the controller, the datapath and the top level; no dependencies.
package gpf_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_PATTERN_COUNT    = 2'd0;
  localparam logic [1:0] REG_MIN_PATTERNS     = 2'd1;
  localparam logic [1:0] REG_MAX_OBJECT_BYTES = 2'd2;

  // Register reset values
  localparam logic [31:0] PATTERN_COUNT_RESET    = 32'd0;
  localparam logic [31:0] MIN_PATTERNS_RESET     = 32'd140;
  localparam logic [47:0] MAX_OBJECT_BYTES_RESET = 48'd45416;

  localparam logic [31:0] DEFAULT_MIN_PATTERNS = 32'd140;
  localparam logic [31:0] HASH_MUL             = 32'd2654435761;
  localparam logic [7:0]  CASE_BIT             = 8'h20;
  localparam logic [15:0] GEN_LAST             = 16'hFFFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic begin_obj;   // start a new object
    logic take_byte;   // slide the window by one data byte
    logic load_query;  // latch key and letter mask of a query
    logic mul;         // hash the current candidate word
    logic stamp;       // write the generation into the hashed slot
    logic next_comb;   // step to the next case combination
    logic clear_step;  // zero one slot of the table
    logic emit_one;    // deliver an unconditional admit
    logic emit_hit;    // deliver the lookup result
  } gpf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic active;      // filter in use for the current object
    logic full;        // window holds three bytes
    logic admit;       // query answers 1 without a lookup
    logic wrap;        // begin item would wrap the generation
    logic hit;         // slot read holds the current generation
    logic last_comb;   // no case combination left
    logic clear_last;  // clearing pass at its final slot
  } gpf_status_t;

endpackage

// File: src/gpf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module gpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: src/gpf_ctrl.sv
// Controller state machine of the gram presence filter.
// Depends on gpf_pkg for the command, status and kind codes.
module gpf_ctrl
  import gpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_kind,
  input  gpf_status_t st,
  output gpf_cmd_t    cmd,
  output logic        busy
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SMUL  = 3'd2;
  localparam logic [2:0] S_STAMP = 3'd3;
  localparam logic [2:0] S_QMUL  = 3'd4;
  localparam logic [2:0] S_QRD   = 3'd5;
  localparam logic [2:0] S_QCMP  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (in_kind)
            KIND_BEGIN: begin
              cmd.begin_obj = 1'b1;
              if (st.wrap) begin
                state_nxt = S_CLEAR;
              end
            end
            KIND_BYTE: begin
              cmd.take_byte = 1'b1;
              if (st.active && st.full) begin
                state_nxt = S_SMUL;
              end
            end
            KIND_QUERY: begin
              if (st.admit) begin
                cmd.emit_one = 1'b1;
              end else begin
                cmd.load_query = 1'b1;
                state_nxt      = S_QMUL;
              end
            end
            default: begin
              // unused kind: drop
            end
          endcase
        end
      end
      S_SMUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_STAMP;
      end
      S_STAMP: begin
        cmd.stamp = 1'b1;
        state_nxt = S_IDLE;
      end
      S_QMUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_QRD;
      end
      S_QRD: begin
        state_nxt = S_QCMP;
      end
      S_QCMP: begin
        if (st.hit || st.last_comb) begin
          cmd.emit_hit = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.next_comb = 1'b1;
          state_nxt     = S_QMUL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !(cmd.begin_obj || cmd.take_byte || cmd.load_query))
    else $error("item taken during clearing pass");

  a_single_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_one && cmd.emit_hit))
    else $error("two results in one cycle");

  a_retry_combo: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QCMP && !(st.hit || st.last_comb)) |=> (state_r == S_QMUL))
    else $error("missed case combination retry");
`endif

endmodule

// File: src/gpf_datapath.sv
// Datapath of the gram presence filter: registers, window, hash and stamp table.
// Depends on gpf_pkg and instantiates gpf_ram for the stamp table.
module gpf_datapath
  import gpf_pkg::*;
#(
  parameter int TABLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  gpf_cmd_t    cmd,
  output gpf_status_t st,
  input  logic [7:0]  in_data_byte,
  input  logic [47:0] in_object_length,
  input  logic [31:0] in_key_bytes,
  input  logic [15:0] in_key_length,
  input  logic        in_ignore_case,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_may_contain
);

  localparam int DEPTH = 1 << TABLE_BITS;

  logic [31:0]           pattern_count_r;
  logic [31:0]           min_patterns_r;
  logic [47:0]           max_object_bytes_r;
  logic [15:0]           gen_r;
  logic [15:0]           gen_nxt;
  logic [23:0]           window_r;
  logic [1:0]            fill_r;
  logic                  active_r;
  logic [31:0]           key_r;
  logic [3:0]            lmask_r;
  logic [3:0]            comb_r;
  logic [31:0]           prod_r;
  logic [TABLE_BITS-1:0] clr_r;
  logic                  out_valid_r;
  logic                  out_may_r;

  logic [31:0]           need;
  logic                  act;
  logic [31:0]           case_clr;
  logic [31:0]           key_sel;
  logic [31:0]           prod_full;
  logic [31:0]           q_base;
  logic [3:0]            q_lmask;
  logic [TABLE_BITS-1:0] slot;
  logic [TABLE_BITS-1:0] ram_addr;
  logic                  ram_we;
  logic [15:0]           ram_wdata;
  logic [15:0]           ram_rdata;

  function automatic logic is_letter(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | CASE_BIT;
    return (lc >= 8'h61) && (lc <= 8'h7A);
  endfunction

  // Activation test of a begin item
  assign need    = (min_patterns_r == 32'd0) ? DEFAULT_MIN_PATTERNS : min_patterns_r;
  assign act     = (in_object_length <= max_object_bytes_r) && (pattern_count_r >= need);
  assign gen_nxt = (gen_r == GEN_LAST) ? 16'd1 : gen_r + 16'd1;

  // With in_ignore_case, fold letters to lower case and mark their positions
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (in_ignore_case && is_letter(in_key_bytes[8*i +: 8])) begin
        q_base[8*i +: 8] = in_key_bytes[8*i +: 8] | CASE_BIT;
        q_lmask[i]       = 1'b1;
      end else begin
        q_base[8*i +: 8] = in_key_bytes[8*i +: 8];
        q_lmask[i]       = 1'b0;
      end
    end
  end

  // Clear the case bit of every letter selected by the combination
  always_comb begin
    case_clr = '0;
    for (int i = 0; i < 4; i++) begin
      case_clr[8*i +: 8] = comb_r[i] ? CASE_BIT : 8'h00;
    end
  end

  assign key_sel   = key_r & ~case_clr;
  assign prod_full = key_sel * HASH_MUL;
  assign slot      = prod_r[31 -: TABLE_BITS];

  assign st.active     = active_r;
  assign st.full       = (fill_r == 2'd3);
  assign st.admit      = !active_r || (in_key_length < 16'd4);
  assign st.wrap       = act && (gen_r == GEN_LAST);
  assign st.hit        = (ram_rdata == gen_r);
  assign st.last_comb  = (comb_r == 4'd0);
  assign st.clear_last = (clr_r == TABLE_BITS'(DEPTH - 1));

  always_comb begin
    ram_we    = cmd.clear_step || cmd.stamp;
    ram_addr  = cmd.clear_step ? clr_r : slot;
    ram_wdata = cmd.clear_step ? 16'd0 : gen_r;
  end

  gpf_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_count_r    <= PATTERN_COUNT_RESET;
      min_patterns_r     <= MIN_PATTERNS_RESET;
      max_object_bytes_r <= MAX_OBJECT_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_COUNT:    pattern_count_r    <= cfg_wdata[31:0];
        REG_MIN_PATTERNS:     min_patterns_r     <= cfg_wdata[31:0];
        REG_MAX_OBJECT_BYTES: max_object_bytes_r <= cfg_wdata;
        default: begin
          // unknown index: drop
        end
      endcase
    end
  end

  // Object state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r    <= 16'd0;
      window_r <= 24'd0;
      fill_r   <= 2'd0;
      active_r <= 1'b0;
      clr_r    <= '0;
    end else begin
      if (cmd.begin_obj) begin
        window_r <= 24'd0;
        fill_r   <= 2'd0;
        active_r <= act;
        if (act) begin
          gen_r <= gen_nxt;
        end
      end
      if (cmd.take_byte && active_r) begin
        window_r <= {in_data_byte, window_r[23:8]};
        if (fill_r != 2'd3) begin
          fill_r <= fill_r + 2'd1;
        end
      end
      if (cmd.clear_step) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  // Candidate word, combination walk and hash product
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      key_r  <= {in_data_byte, window_r};
      comb_r <= 4'd0;
    end else if (cmd.load_query) begin
      key_r   <= q_base;
      lmask_r <= q_lmask;
      comb_r  <= q_lmask;
    end else if (cmd.next_comb) begin
      comb_r <= (comb_r - 4'd1) & lmask_r;
    end
    if (cmd.mul) begin
      prod_r <= prod_full;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_one || cmd.emit_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_one || cmd.emit_hit) begin
      out_may_r <= cmd.emit_one || st.hit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_may_contain = out_may_r;

`ifndef SYNTHESIS
  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (gen_r != 16'd0))
    else $error("active filter with generation zero");
`endif

endmodule

// File: src/gram_presence_filter_unit.sv
// Top level of the gram presence filter: joins controller and datapath.
// Depends on gpf_pkg, gpf_ctrl, gpf_datapath and gpf_ram.
//
// Usage: an item is transferred at a clock edge with start high and busy low.
// in_kind selects begin object, data byte or query; other in_ ports carry that
// kind's fields. Registers are written via cfg_we, cfg_index and cfg_wdata; the
// user must write them only while no item is in flight, unchecked by the block.
// Sequencing: a begin item needs no further step unless it wraps the generation
// (see Reset). A data byte needs none while the window fills or the filter is
// inactive, otherwise a hash and then a stamp write through the single RAM port
// follow. A query admitted without lookup gives its result in the cycle after
// the transfer. A lookup runs multiply, RAM read, compare per case combination,
// 1 to 16 of them, up to the first hit; the result follows the last compare.
// Results: out_valid is high for one cycle with out_may_contain; the receiver
// cannot stall, so the result is taken in that cycle.
// Reset: rst_n is synchronous. After reset, and after a begin item that wraps
// the generation, the stamp table is zeroed one slot a cycle, all 2**TABLE_BITS
// slots, with busy high; register writes are still taken.
module gram_presence_filter_unit
  import gpf_pkg::*;
#(
  parameter int TABLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic [47:0] in_object_length,
  input  logic [31:0] in_key_bytes,
  input  logic [15:0] in_key_length,
  input  logic        in_ignore_case,
  output logic        out_valid,
  output logic        out_may_contain,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  gpf_cmd_t    cmd;
  gpf_status_t st;

  gpf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .st      (st),
    .cmd     (cmd),
    .busy    (busy)
  );

  gpf_datapath #(
    .TABLE_BITS (TABLE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_data_byte     (in_data_byte),
    .in_object_length (in_object_length),
    .in_key_bytes     (in_key_bytes),
    .in_key_length    (in_key_length),
    .in_ignore_case   (in_ignore_case),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_may_contain  (out_may_contain)
  );

endmodule
